/* rtl/iflw_pkg.sv */
`default_nettype none

package iflw_pkg;

  localparam int unsigned MaxLineBytes = 2048;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned PosW        = 12;
  localparam int unsigned LineBytesW  = 12;
  localparam int unsigned FrameLinesW = 11;
  localparam int unsigned FillW       = 11;
  localparam int unsigned IndexW      = 12;
  localparam int unsigned OffsetW     = 22;
  localparam int unsigned FsizeW      = LineBytesW + FrameLinesW;
  localparam int unsigned ModCntW     = $clog2(OffsetW);
  localparam int unsigned CfgIdxW     = 1;

  localparam logic [LineBytesW-1:0]  LineBytesRst  = LineBytesW'(1440);
  localparam logic [FrameLinesW-1:0] FrameLinesRst = FrameLinesW'(576);
  localparam logic [LineBytesW-1:0]  LineBytesCap  = LineBytesW'(MaxLineBytes);
  localparam logic [OffsetW-1:0]     OffsetMax     = '1;
  localparam logic [IndexW-1:0]      IndexMax      = '1;
  localparam logic [ModCntW-1:0]     ModLastCnt    = ModCntW'(OffsetW - 1);

  localparam logic [ByteW-1:0] HdrFieldTwoA = 8'h40;
  localparam logic [ByteW-1:0] HdrFieldTwoB = 8'hC0;
  localparam logic [ByteW-1:0] HdrFieldTwoC = 8'hE0;

  localparam logic [CfgIdxW-1:0] CfgLineBytes  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFrameLines = 1'b1;

  typedef enum logic [1:0] {
    FieldNone = 2'd0,
    FieldOne  = 2'd1,
    FieldTwo  = 2'd2
  } field_e;

  typedef struct packed {
    logic load_in;
    logic load_fsize;
    logic exec;
    logic mod_step;
  } dp_cmd_t;

  typedef struct packed {
    logic payload;
    logic need_mod;
    logic mod_last;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/iflw_ctrl.sv */
`default_nettype none

module iflw_ctrl import iflw_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StLoad,
    StExec,
    StMod
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StLoad;
        end
      end
      StLoad: begin
        cmd_o.load_fsize = 1'b1;
        state_d          = StExec;
      end
      StExec: begin
        if (!stat_i.payload || out_free) begin
          cmd_o.exec = 1'b1;
          if (stat_i.payload) begin
            out_valid_d = 1'b1;
          end
          state_d = stat_i.need_mod ? StMod : StIdle;
        end
      end
      StMod: begin
        cmd_o.mod_step = 1'b1;
        if (stat_i.mod_last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/iflw_dp.sv */
`default_nettype none

module iflw_dp import iflw_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [LineBytesW-1:0]  cfg_data_i,
  input  wire logic [ByteW-1:0]       data_byte_i,
  input  wire logic [PosW-1:0]        byte_pos_i,
  input  wire logic [PosW-1:0]        packet_len_i,
  input  wire dp_cmd_t                cmd_i,
  output dp_stat_t                    stat_o,
  output logic [FillW-1:0]            line_pos_o,
  output logic [ByteW-1:0]            pixel_byte_o,
  output logic                        line_commit_o,
  output logic [OffsetW-1:0]          commit_offset_o,
  output logic                        commit_in_range_o,
  output logic                        frame_done_o
);

  logic [LineBytesW-1:0]  line_bytes_q;
  logic [FrameLinesW-1:0] frame_lines_q;

  logic [ByteW-1:0] byte_q;
  logic [PosW-1:0]  pos_q;
  logic [PosW-1:0]  len_q;
  logic [FsizeW-1:0] fsize_q;

  field_e            prev_q;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [IndexW-1:0] idx_q, idx_d;
  logic [OffsetW-1:0] off_q, off_d;

  logic [OffsetW-1:0] dvd_q;
  logic [OffsetW-1:0] rem_q;
  logic [ModCntW-1:0] cnt_q;

  logic [ByteW-1:0]   pix_q;
  logic [FillW-1:0]   lpos_q;
  logic               commit_q, crange_q, done_q;
  logic [OffsetW-1:0] coff_q;

  logic [LineBytesW-1:0] line_eff;
  logic                  in_range, pos_zero, payload, last, commit, done;
  field_e                fld;
  logic [FillW-1:0]      fill0;
  logic [IndexW-1:0]     idx0, idx1;
  logic [OffsetW-1:0]    off0, off1;
  logic [OffsetW:0]      off_sum;
  logic [IndexW:0]       idx_sum;
  logic [FsizeW-1:0]     shifted, sub;

  assign line_eff = (line_bytes_q > LineBytesCap) ? LineBytesCap : line_bytes_q;
  assign in_range = pos_q < len_q;
  assign pos_zero = (pos_q == '0);
  assign fld = (byte_q == HdrFieldTwoA || byte_q == HdrFieldTwoB ||
                byte_q == HdrFieldTwoC) ? FieldTwo : FieldOne;
  assign payload = in_range && (len_q > PosW'(4)) && (len_q != PosW'(8)) &&
                   (pos_q >= PosW'(4));
  assign last    = (pos_q == len_q - PosW'(1));

  always_comb begin
    fill0 = fill_q;
    idx0  = idx_q;
    off0  = off_q;
    if (in_range && pos_zero) begin
      if (prev_q == FieldTwo && fld == FieldOne) begin
        fill0 = FillW'(1);
        idx0  = '0;
        off0  = '0;
      end
      if (prev_q == FieldOne && fld == FieldTwo) begin
        fill0 = FillW'(1);
        idx0  = IndexW'(1);
        off0  = OffsetW'(line_eff);
      end
    end
  end

  assign commit  = ({1'b0, fill0} + 12'd1) >= line_eff;
  assign off_sum = {1'b0, off0} + {(OffsetW - LineBytesW)'(0), line_eff, 1'b0};
  assign off1    = commit ? (off_sum > {1'b0, OffsetMax} ? OffsetMax : off_sum[OffsetW-1:0])
                          : off0;
  assign idx_sum = {1'b0, idx0} + (IndexW + 1)'(2);
  assign idx1    = commit ? (idx_sum > {1'b0, IndexMax} ? IndexMax : idx_sum[IndexW-1:0])
                          : idx0;
  assign done    = payload && last &&
                   (({1'b0, idx1} + (IndexW + 1)'(1)) >= (IndexW + 1)'(frame_lines_q));

  always_comb begin
    fill_d = fill0;
    idx_d  = idx0;
    off_d  = off0;
    if (payload) begin
      fill_d = commit ? '0 : fill0 + FillW'(1);
      idx_d  = idx1;
      off_d  = off1;
      if (last) begin
        if (done) begin
          fill_d = '0;
          idx_d  = '0;
          off_d  = '0;
        end else if (fsize_q == '0) begin
          off_d = '0;
        end
      end
    end
  end

  assign shifted = {rem_q, dvd_q[OffsetW-1]};
  assign sub     = (shifted >= fsize_q) ? shifted - fsize_q : shifted;

  assign stat_o.payload  = payload;
  assign stat_o.need_mod = payload && last && !done && (fsize_q != '0);
  assign stat_o.mod_last = (cnt_q == ModLastCnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_bytes_q  <= LineBytesRst;
      frame_lines_q <= FrameLinesRst;
      prev_q        <= FieldNone;
      fill_q        <= '0;
      idx_q         <= '0;
      off_q         <= '0;
      cnt_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgLineBytes:  line_bytes_q  <= cfg_data_i;
          CfgFrameLines: frame_lines_q <= cfg_data_i[FrameLinesW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.exec) begin
        if (in_range && pos_zero) begin
          prev_q <= fld;
        end
        fill_q <= fill_d;
        idx_q  <= idx_d;
        off_q  <= off_d;
        cnt_q  <= '0;
      end
      if (cmd_i.mod_step) begin
        cnt_q <= cnt_q + ModCntW'(1);
        if (stat_o.mod_last) begin
          off_q <= sub[OffsetW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      byte_q <= data_byte_i;
      pos_q  <= byte_pos_i;
      len_q  <= packet_len_i;
    end
    if (cmd_i.load_fsize) begin
      fsize_q <= line_eff * frame_lines_q;
    end
    if (cmd_i.exec) begin
      dvd_q <= off1;
      rem_q <= '0;
      if (payload) begin
        pix_q    <= byte_q;
        lpos_q   <= fill0;
        commit_q <= commit;
        coff_q   <= commit ? off0 : '0;
        crange_q <= commit && ({1'b0, off0} < fsize_q);
        done_q   <= done;
      end
    end
    if (cmd_i.mod_step) begin
      dvd_q <= {dvd_q[OffsetW-2:0], 1'b0};
      rem_q <= sub[OffsetW-1:0];
    end
  end

  assign line_pos_o        = lpos_q;
  assign pixel_byte_o      = pix_q;
  assign line_commit_o     = commit_q;
  assign commit_offset_o   = coff_q;
  assign commit_in_range_o = crange_q;
  assign frame_done_o      = done_q;

endmodule

`default_nettype wire

/* rtl/interlaced_field_line_weaver_unit.sv */
// Interlaced field line weaver.
// Input channel (in_valid_i/in_ready_o) takes one capture packet byte per item
// with its position and packet length. Output channel (out_valid_o/out_ready_i)
// gives one item per payload byte: line store position and byte, plus line
// commit, commit offset, in-range flag and frame done. Header bytes, short
// packets and out-of-range positions give no item.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes line_bytes (index 0)
// or frame_lines (index 1); it is always ready. Write only while idle.
// Each item passes through the load and execute states to its result in the
// output register; the byte that ends a payload packet and does not end the
// frame, with a nonzero frame size, then wraps the frame offset modulo the
// frame size, one remainder bit per cycle. A new item is accepted only once
// the unit is back in idle. The output register holds a result while the
// receiver stalls; the next item is still accepted and waits only when it has
// its own result to place. Reset clears the field, line and offset state and
// loads the register defaults of 1440 line bytes and 576 frame lines.
`default_nettype none

module interlaced_field_line_weaver_unit import iflw_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [LineBytesW-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [ByteW-1:0]      data_byte_i,
  input  wire logic [PosW-1:0]       byte_pos_i,
  input  wire logic [PosW-1:0]       packet_len_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [FillW-1:0]           line_pos_o,
  output logic [ByteW-1:0]           pixel_byte_o,
  output logic                       line_commit_o,
  output logic [OffsetW-1:0]         commit_offset_o,
  output logic                       commit_in_range_o,
  output logic                       frame_done_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  iflw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  iflw_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .data_byte_i       (data_byte_i),
    .byte_pos_i        (byte_pos_i),
    .packet_len_i      (packet_len_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .line_pos_o        (line_pos_o),
    .pixel_byte_o      (pixel_byte_o),
    .line_commit_o     (line_commit_o),
    .commit_offset_o   (commit_offset_o),
    .commit_in_range_o (commit_in_range_o),
    .frame_done_o      (frame_done_o)
  );

endmodule

`default_nettype wire
